FILE: hw/rtl/hkr_pkg.sv
`default_nettype none

package hkr_pkg;

    localparam int SLOTS        = 6;
    localparam int OUT_SLOTS    = 6;
    localparam int REPORT_LEN_W = 4;
    localparam int LEN_W        = ($clog2(SLOTS + 3) > REPORT_LEN_W) ?
                                  $clog2(SLOTS + 3) : REPORT_LEN_W;

    localparam logic [4:0]              MOD_PREFIX  = 5'b11100;
    localparam logic [7:0]              EMPTY_KEY   = 8'h00;
    localparam logic [REPORT_LEN_W-1:0] LEN_MAX     = '1;
    localparam logic [REPORT_LEN_W-1:0] LEN_NONE    = '0;
    localparam logic [REPORT_LEN_W-1:0] LEN_MIN_REL = REPORT_LEN_W'(2);

    typedef logic [7:0]                 key_t;
    typedef key_t [SLOTS-1:0]           slots_t;
    typedef key_t [OUT_SLOTS-1:0]       out_slots_t;

    typedef struct packed {
        logic [7:0]              modifiers;
        out_slots_t              slots;
        logic                    send_report;
        logic [REPORT_LEN_W-1:0] report_len;
    } report_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hid_keyboard_report_tracker.sv
// channel | direction | payload                                   | handshake
// s_      | in        | pressed, key_code                         | s_valid/s_ready
// m_      | out       | modifiers, slot0..5, send_report, len     | m_valid/m_ready
//
// One event per cycle sustained while the result is not stalled.
// Event is captured in an input register, then the slot update and result are
// computed in one pass and loaded into the result register and state together.
// aresetn (synchronous) clears modifiers, slots and both valid flags.
// A stalled result holds the input register; s_ready drops only when both are full.
`default_nettype none

module hid_keyboard_report_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_pressed,
    input  wire logic [7:0]  s_key_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_modifiers,
    output logic [7:0]       m_slot0,
    output logic [7:0]       m_slot1,
    output logic [7:0]       m_slot2,
    output logic [7:0]       m_slot3,
    output logic [7:0]       m_slot4,
    output logic [7:0]       m_slot5,
    output logic             m_send_report,
    output logic [3:0]       m_report_len
);

    logic              in_valid_reg;
    logic              in_pressed_reg;
    logic [7:0]        in_code_reg;
    logic              out_valid_reg;
    hkr_pkg::report_t  out_reg;
    logic [7:0]        mods_reg;
    logic [7:0]        mods_next;
    hkr_pkg::slots_t   slots_reg;
    hkr_pkg::slots_t   slots_next;
    hkr_pkg::report_t  report;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hkr_update u_update (
        .pressed    (in_pressed_reg),
        .key_code   (in_code_reg),
        .mods       (mods_reg),
        .slots      (slots_reg),
        .mods_next  (mods_next),
        .slots_next (slots_next),
        .report     (report)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mods_reg      <= '0;
            slots_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mods_reg      <= mods_next;
                slots_reg     <= slots_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_pressed_reg <= s_pressed;
            in_code_reg    <= s_key_code;
        end
        if (advance) begin
            out_reg <= report;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_modifiers   = out_reg.modifiers;
    assign m_slot0       = out_reg.slots[0];
    assign m_slot1       = out_reg.slots[1];
    assign m_slot2       = out_reg.slots[2];
    assign m_slot3       = out_reg.slots[3];
    assign m_slot4       = out_reg.slots[4];
    assign m_slot5       = out_reg.slots[5];
    assign m_send_report = out_reg.send_report;
    assign m_report_len  = out_reg.report_len;

`ifndef SYNTH
    a_len_zero_no_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_report |-> m_report_len == hkr_pkg::LEN_NONE)
        else $error("report length set without a report request");

    a_len_min_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_report |-> m_report_len >= hkr_pkg::LEN_MIN_REL)
        else $error("report length below header size");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(slots_reg) && $stable(mods_reg))
        else $error("key state changed without a beat");

    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled while pipeline could move");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_code_reg)
        && $stable(in_pressed_reg))
        else $error("held event lost during result stall");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/hkr_update.sv
`default_nettype none

module hkr_update (
    input  wire logic           pressed,
    input  wire logic [7:0]     key_code,
    input  wire logic [7:0]     mods,
    input  wire hkr_pkg::slots_t slots,
    output logic [7:0]          mods_next,
    output hkr_pkg::slots_t     slots_next,
    output hkr_pkg::report_t    report
);

    logic                                  is_mod;
    logic [7:0]                            mod_bit;
    logic [hkr_pkg::SLOTS:0][7:0]          ext;
    logic [hkr_pkg::SLOTS+hkr_pkg::OUT_SLOTS-1:0][7:0] pad;
    logic                                  found;
    logic                                  active;
    logic                                  send;
    logic [hkr_pkg::LEN_W-1:0]             len;

    assign is_mod  = (key_code[7:3] == hkr_pkg::MOD_PREFIX);
    assign mod_bit = 8'(1) << key_code[2:0];
    assign ext     = {hkr_pkg::EMPTY_KEY, slots};

    always_comb begin
        mods_next  = mods;
        slots_next = slots;
        found      = 1'b0;
        active     = 1'b0;
        send       = 1'b0;
        len        = '0;
        if (is_mod) begin
            if (pressed) begin
                mods_next = mods | mod_bit;
            end else begin
                mods_next = mods & ~mod_bit;
            end
        end else if (pressed) begin
            for (int j = 0; j < hkr_pkg::SLOTS; j++) begin
                if (!found && slots[j] == hkr_pkg::EMPTY_KEY) begin
                    slots_next[j] = key_code;
                    found         = 1'b1;
                    send          = 1'b1;
                    len           = hkr_pkg::LEN_W'(j + 3);
                end
            end
        end else begin
            send = 1'b1;
            len  = hkr_pkg::LEN_W'(hkr_pkg::SLOTS + 2);
            for (int j = 0; j < hkr_pkg::SLOTS; j++) begin
                if (!found && slots[j] == key_code) begin
                    found  = 1'b1;
                    active = 1'b1;
                end
                if (active) begin
                    slots_next[j] = ext[j+1];
                    if (ext[j+1] == hkr_pkg::EMPTY_KEY) begin
                        len    = hkr_pkg::LEN_W'(j + 2);
                        active = 1'b0;
                    end
                end
            end
        end
    end

    // slots beyond the configured count read as empty
    assign pad = {{hkr_pkg::OUT_SLOTS{hkr_pkg::EMPTY_KEY}}, slots_next};

    always_comb begin
        report.modifiers   = mods_next;
        report.send_report = send;
        for (int k = 0; k < hkr_pkg::OUT_SLOTS; k++) begin
            report.slots[k] = pad[k];
        end
        if (!send) begin
            report.report_len = hkr_pkg::LEN_NONE;
        end else if (len > hkr_pkg::LEN_W'(hkr_pkg::LEN_MAX)) begin
            report.report_len = hkr_pkg::LEN_MAX;
        end else begin
            report.report_len = len[hkr_pkg::REPORT_LEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_hid_keyboard_report_tracker.sv
`timescale 1ns / 100ps

module tb_hid_keyboard_report_tracker;
    import hkr_pkg::*;

    typedef struct packed {
        logic    pressed;
        key_t    code;
        logic    fixed;
        report_t want;
    } event_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_pressed = 1'b0;
    logic [7:0] s_key_code = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_modifiers;
    logic [7:0] m_slot0, m_slot1, m_slot2, m_slot3, m_slot4, m_slot5;
    logic       m_send_report;
    logic [3:0] m_report_len;

    logic [7:0] mod_state = 8'h00;
    key_t       held_keys [SLOTS];
    report_t    pending_reports [$];
    event_row_t event_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int err_count = 0;
    int reports_seen = 0;
    int random_events = 0;
    int input_stalls = 0;

    hid_keyboard_report_tracker uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pressed     (s_pressed),
        .s_key_code    (s_key_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_modifiers   (m_modifiers),
        .m_slot0       (m_slot0),
        .m_slot1       (m_slot1),
        .m_slot2       (m_slot2),
        .m_slot3       (m_slot3),
        .m_slot4       (m_slot4),
        .m_slot5       (m_slot5),
        .m_send_report (m_send_report),
        .m_report_len  (m_report_len)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic report_t lit_report(input logic [7:0] mods, input key_t first,
                                           input logic send, input logic [3:0] len);
        report_t r;
        r = '0;
        r.modifiers = mods;
        r.slots[0] = first;
        r.send_report = send;
        r.report_len = len;
        return r;
    endfunction

    // Keyboard state update for one event; returns the report it produces.
    task automatic track_event(input logic pr, input key_t code, output report_t r);
        int   i;
        int   k;
        int   n;
        logic want;
        key_t nxt;
        begin
            want = 1'b0;
            n = 0;
            if (code[7:3] == MOD_PREFIX) begin
                mod_state[code[2:0]] = pr;
            end else if (pr) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (held_keys[i] == EMPTY_KEY) begin
                        held_keys[i] = code;
                        want = 1'b1;
                        n = i + 3;
                        break;
                    end
                end
            end else begin
                for (i = 0; i < SLOTS; i++)
                    if (held_keys[i] == code)
                        break;
                for (; i < SLOTS; i++) begin
                    nxt = (i + 1 < SLOTS) ? held_keys[i + 1] : EMPTY_KEY;
                    held_keys[i] = nxt;
                    if (nxt == EMPTY_KEY)
                        break;
                end
                want = 1'b1;
                n = i + 2;
            end
            r = '0;
            r.modifiers = mod_state;
            for (k = 0; k < OUT_SLOTS; k++)
                r.slots[k] = (k < SLOTS) ? held_keys[k] : EMPTY_KEY;
            r.send_report = want;
            r.report_len = want ? ((n > 15) ? LEN_MAX : n[REPORT_LEN_W-1:0]) : LEN_NONE;
        end
    endtask

    task automatic add_row(input logic pr, input key_t code, input logic fixed,
                           input report_t want);
        event_row_t row;
        begin
            row.pressed = pr;
            row.code = code;
            row.fixed = fixed;
            row.want = want;
            event_rows.push_back(row);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_event(input logic pr, input key_t code, input logic fixed,
                              input report_t lit);
        report_t r;
        begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_pressed <= pr;
            s_key_code <= code;
            do @(posedge aclk); while (!s_ready);
            track_event(pr, code, r);
            pending_reports.push_back(fixed ? lit : r);
            @(negedge aclk);
        end
    endtask

    task automatic drain_reports;
        begin
            s_valid <= 1'b0;
            while (pending_reports.size() != 0)
                @(posedge aclk);
            @(negedge aclk);
        end
    endtask

    task automatic random_event(output logic pr, output key_t code);
        int sel;
        int cnt;
        int k;
        begin
            sel = $urandom_range(0, 99);
            cnt = 0;
            for (k = 0; k < SLOTS; k++)
                if (held_keys[k] != EMPTY_KEY)
                    cnt++;
            if (sel < 15) begin
                pr = 1'($urandom_range(0, 1));
                code = {MOD_PREFIX, 3'($urandom_range(0, 7))};
            end else if (sel < 55) begin
                pr = 1'b1;
                code = ($urandom_range(0, 9) < 7) ? key_t'($urandom_range(8'h04, 8'h0b))
                                                   : key_t'($urandom_range(0, 255));
            end else if (sel < 88 && cnt > 0) begin
                pr = 1'b0;
                code = held_keys[$urandom_range(0, cnt - 1)];
            end else begin
                pr = 1'($urandom_range(0, 1));
                code = key_t'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %02h actual %02h", $time, what, want, got);
        end
    endtask

    // Receiver: random backpressure, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 64;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : report_monitor
        report_t   want;
        out_slots_t got_slots;
        int        k;
        if (aresetn) begin
            if (s_valid && !s_ready)
                input_stalls++;
            if (m_valid && m_ready) begin
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    err_count++;
                    $display("%0t ns: report beat with nothing expected", $time);
                end else begin
                    want = pending_reports.pop_front();
                    got_slots = {m_slot5, m_slot4, m_slot3, m_slot2, m_slot1, m_slot0};
                    check_field("modifiers", want.modifiers, m_modifiers);
                    for (k = 0; k < OUT_SLOTS; k++)
                        check_field($sformatf("slot%0d", k), want.slots[k], got_slots[k]);
                    check_field("send_report", want.send_report, m_send_report);
                    check_field("report_len", want.report_len, m_report_len);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("hid_keyboard_report_tracker regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic    pr;
        key_t    code;
        int      p;
        int      n;
        int      guard;

        for (n = 0; n < SLOTS; n++)
            held_keys[n] = EMPTY_KEY;

        add_row(1'b0, 8'h04, 1'b1, lit_report(8'h00, 8'h00, 1'b1, 4'd8));
        add_row(1'b1, 8'he0, 1'b1, lit_report(8'h01, 8'h00, 1'b0, LEN_NONE));
        add_row(1'b1, 8'he7, 1'b1, lit_report(8'h81, 8'h00, 1'b0, LEN_NONE));
        add_row(1'b0, 8'he0, 1'b1, lit_report(8'h80, 8'h00, 1'b0, LEN_NONE));
        add_row(1'b1, 8'h04, 1'b1, lit_report(8'h80, 8'h04, 1'b1, 4'd3));
        add_row(1'b1, 8'hff, 1'b0, '0);
        add_row(1'b1, 8'h04, 1'b0, '0);    // duplicate press
        add_row(1'b1, 8'h00, 1'b0, '0);    // zero code press
        add_row(1'b1, 8'hdf, 1'b0, '0);
        add_row(1'b1, 8'he8, 1'b0, '0);
        add_row(1'b1, 8'h01, 1'b0, '0);    // slots now full
        add_row(1'b1, 8'h1e, 1'b0, '0);
        add_row(1'b1, 8'h00, 1'b0, '0);
        add_row(1'b0, 8'h00, 1'b0, '0);
        add_row(1'b0, 8'h01, 1'b0, '0);    // last slot
        add_row(1'b0, 8'h04, 1'b0, '0);    // first match, shift up
        add_row(1'b0, 8'h55, 1'b0, '0);    // absent
        add_row(1'b0, 8'h00, 1'b0, '0);    // zero code matches empty slot
        add_row(1'b0, 8'he7, 1'b0, '0);
        add_row(1'b1, 8'he3, 1'b0, '0);
        add_row(1'b0, 8'hff, 1'b0, '0);
        add_row(1'b0, 8'h04, 1'b0, '0);
        add_row(1'b0, 8'hdf, 1'b0, '0);
        add_row(1'b0, 8'he8, 1'b0, '0);
        add_row(1'b0, 8'he3, 1'b0, '0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 83;
        foreach (event_rows[i])
            send_event(event_rows[i].pressed, event_rows[i].code, event_rows[i].fixed,
                       event_rows[i].want);
        drain_reports();

        for (p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 32 : (p == 1) ? 83 : 0;
            recv_idle_pct = (p == 0) ? 83 : (p == 1) ? 32 : 0;
            if (p == 2)
                hold_req = 1'b1;
            for (n = 0; n < 300; n++) begin
                random_event(pr, code);
                send_event(pr, code, 1'b0, '0);
                random_events++;
            end
            drain_reports();
        end

        guard = 0;
        while (pending_reports.size() != 0 && guard < 10000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            err_count++;
            $display("%0t ns: %0d reports never arrived", $time, pending_reports.size());
        end

        $display("Ran %0d table events and %0d random key events; %0d reports checked.",
                 event_rows.size(), random_events, reports_seen);
        $display("Input stalled %0d cycles under backpressure; %0d mismatches.",
                 input_stalls, err_count);
        if (err_count == 0) begin
            $display("hid_keyboard_report_tracker regression: pass");
        end else begin
            $display("hid_keyboard_report_tracker regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hkr_pkg.sv
hw/rtl/hkr_update.sv
hw/rtl/hid_keyboard_report_tracker.sv
tb/tb_hid_keyboard_report_tracker.sv
